### hw/rtl/wap_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package wap_pkg;

    // Block sizing.
    localparam int MOTORS_DEF = 4;
    localparam int ENC_COUNTS = 8192;
    localparam int ENC_HALF   = ENC_COUNTS / 2;

    // Port field widths.
    localparam int SEL_W = 2;
    localparam int ANG_W = 14;
    localparam int DRV_W = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_W     = 16;
    localparam int LIM_W      = 15;
    localparam int FRAC_W     = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_LIMIT = CFG_IDX_W'(4);

    localparam logic [GAIN_W-1:0] PROP_GAIN_RST   = GAIN_W'(20480);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST  = GAIN_W'(384);
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST  = GAIN_W'(640);
    localparam logic [LIM_W-1:0]  INTEG_LIMIT_RST = LIM_W'(10000);
    localparam logic [LIM_W-1:0]  DRIVE_LIMIT_RST = LIM_W'(20000);

    // Angle difference and wrap arithmetic.
    localparam int DIFF_W   = ANG_W + 1;
    localparam int DIFF_MAX = (1 << ANG_W) - 1;
    localparam int OFS_MULT = (DIFF_MAX + ENC_COUNTS - 1) / ENC_COUNTS;
    localparam int X_OFS    = ENC_HALF + OFS_MULT * ENC_COUNTS;
    localparam int X_W      = $clog2(DIFF_MAX + X_OFS + 1);
    localparam int VAL_W    = X_W + 1;
    localparam int RECIP_SH = X_W;
    localparam int RECIP_W  = X_W + 1;
    localparam int RECIP    = (1 << RECIP_SH) / ENC_COUNTS;

    localparam logic [RECIP_W-1:0]      RECIP_V    = RECIP_W'(RECIP);
    localparam logic [X_W-1:0]          ENC_U      = X_W'(ENC_COUNTS);
    localparam logic signed [VAL_W-1:0] ENC_V      = VAL_W'(ENC_COUNTS);
    localparam logic signed [VAL_W-1:0] HALF_V     = VAL_W'(ENC_HALF);
    localparam logic signed [VAL_W-1:0] NEG_HALF_V = VAL_W'(-ENC_HALF);
    localparam logic signed [VAL_W-1:0] POS_LO_V   = VAL_W'(ENC_HALF + 1 - ENC_COUNTS);
    localparam logic signed [VAL_W-1:0] X_OFS_V    = VAL_W'(X_OFS);

    localparam int WRAP_MAX = (ENC_HALF < DIFF_MAX) ? ENC_HALF : DIFF_MAX;
    localparam int ERR_W    = $clog2(WRAP_MAX + 1) + 1;

    // Controller datapath widths.
    localparam int INT_W   = LIM_W + FRAC_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + ERR_W;
    localparam int DERR_W  = ERR_W + 1;
    localparam int D_W     = GAIN_W + 1 + DERR_W;
    localparam int ISUM_W  = ((PROD_W > INT_W) ? PROD_W : INT_W) + 1;
    localparam int TOT_W   = D_W + 2;

    // Output buffer.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [GAIN_W-1:0] prop_gain;
        logic [GAIN_W-1:0] integ_gain;
        logic [GAIN_W-1:0] deriv_gain;
        logic [LIM_W-1:0]  integ_limit;
        logic [LIM_W-1:0]  drive_limit;
    } t_gains;

    typedef struct packed {
        logic                    valid;
        logic                    in_range;
        logic [SEL_W-1:0]        sel;
        logic signed [ERR_W-1:0] err;
    } t_wrap_item;

    typedef struct packed {
        logic signed [ERR_W-1:0] prev_err;
        logic signed [INT_W-1:0] integ;
    } t_state;

    typedef struct packed {
        logic [SEL_W-1:0]        motor;
        logic signed [DRV_W-1:0] drive;
    } t_out;

    typedef struct packed {
        logic valid;
        t_out word;
    } t_result;

endpackage

`default_nettype wire

### hw/rtl/wap_wrap.sv
`timescale 1ns / 1ps
`default_nettype none

module wap_wrap #(
    parameter int MOTORS = wap_pkg::MOTORS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_accept,
    input  wire logic [wap_pkg::SEL_W-1:0]           i_motor_sel,
    input  wire logic signed [wap_pkg::ANG_W-1:0]    i_target_angle,
    input  wire logic signed [wap_pkg::ANG_W-1:0]    i_measured_angle,
    output wap_pkg::t_wrap_item                      o_item
);

    localparam int X_W    = wap_pkg::X_W;
    localparam int VAL_W  = wap_pkg::VAL_W;
    localparam int DIFF_W = wap_pkg::DIFF_W;
    localparam int ERR_W  = wap_pkg::ERR_W;
    localparam int SEL_W  = wap_pkg::SEL_W;
    localparam int MUL1_W = X_W + wap_pkg::RECIP_W;
    localparam int MUL2_W = 2 * X_W;

    // Stage A: raw difference and its offset copy, which is never negative.
    logic                     r_a_vld, r_a_inr;
    logic [SEL_W-1:0]         r_a_sel;
    logic signed [DIFF_W-1:0] r_a_e;
    logic [X_W-1:0]           r_a_x;

    // Stage B: quotient estimate by reciprocal multiply.
    logic                     r_b_vld, r_b_inr;
    logic [SEL_W-1:0]         r_b_sel;
    logic signed [DIFF_W-1:0] r_b_e;
    logic [X_W-1:0]           r_b_x;
    logic [X_W-1:0]           r_b_q;

    // Stage C: remainder before correction, below twice the turn size.
    logic                     r_c_vld, r_c_inr;
    logic [SEL_W-1:0]         r_c_sel;
    logic signed [DIFF_W-1:0] r_c_e;
    logic [X_W-1:0]           r_c_r0;

    // Stage D: wrapped error.
    logic                     r_d_vld, r_d_inr;
    logic [SEL_W-1:0]         r_d_sel;
    logic signed [ERR_W-1:0]  r_d_err;

    logic signed [DIFF_W-1:0] n_a_e;
    logic [X_W-1:0]           n_a_x;
    logic                     n_a_inr;
    logic [MUL1_W-1:0]        b_prod;
    logic [MUL2_W-1:0]        c_prod;
    logic [X_W-1:0]           d_r;
    logic signed [VAL_W-1:0]  d_w, d_e, d_err;

    assign n_a_e   = DIFF_W'(i_target_angle) - DIFF_W'(i_measured_angle);
    assign n_a_x   = X_W'(VAL_W'(n_a_e) + wap_pkg::X_OFS_V);
    assign n_a_inr = (int'(i_motor_sel) < MOTORS);

    assign b_prod = MUL1_W'(r_a_x) * MUL1_W'(wap_pkg::RECIP_V);
    assign c_prod = MUL2_W'(r_b_q) * MUL2_W'(wap_pkg::ENC_U);

    // A result above half a turn keeps the upper end of the range, one below
    // keeps the lower end, so both ends are reachable.
    always_comb begin
        d_r = (r_c_r0 >= wap_pkg::ENC_U) ? r_c_r0 - wap_pkg::ENC_U : r_c_r0;
        d_w = $signed({1'b0, d_r}) - wap_pkg::HALF_V;
        d_e = VAL_W'(r_c_e);
        if (d_e > wap_pkg::HALF_V) begin
            d_err = (d_w < wap_pkg::POS_LO_V) ? d_w + wap_pkg::ENC_V : d_w;
        end else if (d_e < wap_pkg::NEG_HALF_V) begin
            d_err = d_w;
        end else begin
            d_err = d_e;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
        end else begin
            r_a_vld <= i_accept;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_inr <= n_a_inr;
        r_a_sel <= i_motor_sel;
        r_a_e   <= n_a_e;
        r_a_x   <= n_a_x;

        r_b_inr <= r_a_inr;
        r_b_sel <= r_a_sel;
        r_b_e   <= r_a_e;
        r_b_x   <= r_a_x;
        r_b_q   <= b_prod[wap_pkg::RECIP_SH +: X_W];

        r_c_inr <= r_b_inr;
        r_c_sel <= r_b_sel;
        r_c_e   <= r_b_e;
        r_c_r0  <= r_b_x - c_prod[X_W-1:0];

        r_d_inr <= r_c_inr;
        r_d_sel <= r_c_sel;
        r_d_err <= ERR_W'(d_err);
    end

    assign o_item = '{valid: r_d_vld, in_range: r_d_inr, sel: r_d_sel, err: r_d_err};

endmodule

`default_nettype wire

### hw/rtl/wap_state_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module wap_state_mem #(
    parameter int MOTORS = wap_pkg::MOTORS_DEF,
    localparam int AW    = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic [AW-1:0]   i_rd_addr,
    input  wire logic            i_wr_en,
    input  wire logic [AW-1:0]   i_wr_addr,
    input  wire wap_pkg::t_state i_wr_data,
    output wap_pkg::t_state      o_rd_data
);

    wap_pkg::t_state r_mem [MOTORS];
    wap_pkg::t_state r_rd_data;
    wap_pkg::t_state r_fwd_data;
    logic [MOTORS-1:0] r_vld;
    logic              r_rd_vld;
    logic              r_fwd;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data  <= r_mem[i_rd_addr];
        r_fwd_data <= i_wr_data;
    end

    // An entry never written since reset reads as zero. A write to the
    // entry being read in the same cycle is forwarded past the array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
            r_fwd    <= i_wr_en && (i_wr_addr == i_rd_addr);
        end
    end

    assign o_rd_data = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : '0);

endmodule

`default_nettype wire

### hw/rtl/wap_update.sv
`timescale 1ns / 1ps
`default_nettype none

module wap_update #(
    parameter int MOTORS = wap_pkg::MOTORS_DEF,
    localparam int AW    = (MOTORS > 1) ? $clog2(MOTORS) : 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire wap_pkg::t_gains     i_gains,
    input  wire wap_pkg::t_wrap_item i_item,
    output logic [AW-1:0]            o_rd_addr,
    input  wire wap_pkg::t_state     i_rd_data,
    output logic                     o_wr_en,
    output logic [AW-1:0]            o_wr_addr,
    output wap_pkg::t_state          o_wr_data,
    output wap_pkg::t_result         o_result
);

    localparam int ERR_W  = wap_pkg::ERR_W;
    localparam int INT_W  = wap_pkg::INT_W;
    localparam int PROD_W = wap_pkg::PROD_W;
    localparam int DERR_W = wap_pkg::DERR_W;
    localparam int D_W    = wap_pkg::D_W;
    localparam int ISUM_W = wap_pkg::ISUM_W;
    localparam int TOT_W  = wap_pkg::TOT_W;
    localparam int SEL_W  = wap_pkg::SEL_W;
    localparam int DRV_W  = wap_pkg::DRV_W;
    localparam int FRAC_W = wap_pkg::FRAC_W;

    // Stage E: gain products that do not depend on the stored state.
    logic                     r_e_vld, r_e_inr;
    logic [SEL_W-1:0]         r_e_sel;
    logic signed [ERR_W-1:0]  r_e_err;
    logic signed [PROD_W-1:0] r_e_p, r_e_ip;

    // Stage F: the three terms of the sum.
    logic                     r_f_vld, r_f_inr;
    logic [SEL_W-1:0]         r_f_sel;
    logic signed [PROD_W-1:0] r_f_p;
    logic signed [INT_W-1:0]  r_f_integ;
    logic signed [D_W-1:0]    r_f_d;

    logic signed [PROD_W-1:0] n_e_p, n_e_ip;
    logic signed [ISUM_W-1:0] e_isum, e_ilim, e_iclamp;
    logic signed [INT_W-1:0]  e_integ;
    logic signed [DERR_W-1:0] e_derr;
    logic signed [D_W-1:0]    e_d;
    logic signed [TOT_W-1:0]  f_tot, f_quot, f_lim, f_drive;

    assign n_e_p  = PROD_W'($signed({1'b0, i_gains.prop_gain})) * PROD_W'($signed(i_item.err));
    assign n_e_ip = PROD_W'($signed({1'b0, i_gains.integ_gain})) * PROD_W'($signed(i_item.err));

    assign o_rd_addr = AW'(i_item.sel);

    always_comb begin
        e_isum = ISUM_W'($signed(i_rd_data.integ)) + ISUM_W'(r_e_ip);
        e_ilim = $signed(ISUM_W'({i_gains.integ_limit, {FRAC_W{1'b0}}}));
        if (e_isum > e_ilim) begin
            e_iclamp = e_ilim;
        end else if (e_isum < -e_ilim) begin
            e_iclamp = -e_ilim;
        end else begin
            e_iclamp = e_isum;
        end
        e_integ = INT_W'(e_iclamp);
        e_derr  = DERR_W'(r_e_err) - DERR_W'($signed(i_rd_data.prev_err));
        e_d     = D_W'($signed({1'b0, i_gains.deriv_gain})) * D_W'(e_derr);
    end

    assign o_wr_en   = r_e_vld && r_e_inr;
    assign o_wr_addr = AW'(r_e_sel);
    assign o_wr_data = '{prev_err: r_e_err, integ: e_integ};

    // The sum carries eight fraction bits; drop them rounding toward zero, then clamp to the drive limit.
    always_comb begin
        f_tot  = TOT_W'(r_f_p) + TOT_W'(r_f_integ) + TOT_W'(r_f_d);
        f_quot = f_tot >>> FRAC_W;
        if (f_tot[TOT_W-1] && (f_tot[FRAC_W-1:0] != '0)) begin
            f_quot = f_quot + TOT_W'(1);
        end
        f_lim = $signed(TOT_W'(i_gains.drive_limit));
        if (f_quot > f_lim) begin
            f_drive = f_lim;
        end else if (f_quot < -f_lim) begin
            f_drive = -f_lim;
        end else begin
            f_drive = f_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else begin
            r_e_vld <= i_item.valid;
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_inr   <= i_item.in_range;
        r_e_sel   <= i_item.sel;
        r_e_err   <= i_item.err;
        r_e_p     <= n_e_p;
        r_e_ip    <= n_e_ip;

        r_f_inr   <= r_e_inr;
        r_f_sel   <= r_e_sel;
        r_f_p     <= r_e_p;
        r_f_integ <= e_integ;
        r_f_d     <= e_d;
    end

    assign o_result.valid      = r_f_vld;
    assign o_result.word.motor = r_f_sel;
    assign o_result.word.drive = r_f_inr ? DRV_W'(f_drive) : '0;

endmodule

`default_nettype wire

### hw/rtl/wap_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module wap_out_fifo (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire wap_pkg::t_result i_push,
    input  wire logic             i_pop,
    output logic                  o_valid,
    output wap_pkg::t_out         o_word
);

    localparam int AW = wap_pkg::FIFO_AW;
    localparam int CW = wap_pkg::FIFO_CW;

    wap_pkg::t_out r_mem [wap_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.word;
        end
    end

    // The sender limits outstanding words to the depth, so a push never
    // finds the buffer full.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + AW'(1);
            end
            case ({i_push.valid, i_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_valid = (r_count != '0);
    assign o_word  = r_mem[r_rd_ptr];

endmodule

`default_nettype wire

### hw/rtl/wrapped_angle_pid_unit.sv
// Per-motor positional PID with the angle error wrapped into half a turn.
// Input channel: i_in_valid / o_in_stall with i_motor_sel, i_target_angle and
// i_measured_angle. A word is taken at a clock edge with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_motor_out and o_drive_value.
// Configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// ready is always high. Registers 0..4 are proportional gain, integral gain,
// derivative gain, integrator limit and drive limit. Write them only while idle.
// Each word passes wrap stages A-D and update stages E-F into the output buffer.
// Throughput: one word per cycle while not stalled, set by a six stage pipeline
// whose controller state sits in a one-read, one-write memory; the following item
// to the same motor picks up the new state through a forwarding path.
// Reset loads the default gains and limits and clears every motor's previous
// error and integrator (per-entry valid bits, no clearing pass needed).
// While the receiver stalls, results collect in an eight-word output buffer and
// input keeps flowing; o_in_stall rises once eight words are outstanding.
// A motor select at or above MOTORS changes no state and returns a drive of zero.
`timescale 1ns / 1ps
`default_nettype none

module wrapped_angle_pid_unit #(
    parameter int MOTORS = wap_pkg::MOTORS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire logic [wap_pkg::SEL_W-1:0]             i_motor_sel,
    input  wire logic signed [wap_pkg::ANG_W-1:0]      i_target_angle,
    input  wire logic signed [wap_pkg::ANG_W-1:0]      i_measured_angle,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output logic [wap_pkg::SEL_W-1:0]                  o_motor_out,
    output logic signed [wap_pkg::DRV_W-1:0]           o_drive_value,
    input  wire logic                                  i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  wire logic [wap_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  wire logic [wap_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW     = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CW     = wap_pkg::FIFO_CW;
    localparam int LIM_W  = wap_pkg::LIM_W;
    localparam int GAIN_W = wap_pkg::GAIN_W;

    logic [GAIN_W-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic [LIM_W-1:0]  r_integ_limit, r_drive_limit;
    logic [CW-1:0]     r_outstanding;

    logic                in_acc, out_acc, cfg_wr;
    wap_pkg::t_gains     gains;
    wap_pkg::t_wrap_item item;
    wap_pkg::t_state     rd_data, wr_data;
    wap_pkg::t_result    result;
    wap_pkg::t_out       out_word;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic                wr_en;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_outstanding == CW'(wap_pkg::FIFO_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= wap_pkg::PROP_GAIN_RST;
            r_integ_gain  <= wap_pkg::INTEG_GAIN_RST;
            r_deriv_gain  <= wap_pkg::DERIV_GAIN_RST;
            r_integ_limit <= wap_pkg::INTEG_LIMIT_RST;
            r_drive_limit <= wap_pkg::DRIVE_LIMIT_RST;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                wap_pkg::CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                wap_pkg::CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                wap_pkg::CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                wap_pkg::CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIM_W-1:0];
                wap_pkg::CFG_DRIVE_LIMIT: r_drive_limit <= i_cfg_data[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Words taken but not yet delivered: in the pipeline or in the buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outstanding <= '0;
        end else begin
            case ({in_acc, out_acc})
                2'b10:   r_outstanding <= r_outstanding + CW'(1);
                2'b01:   r_outstanding <= r_outstanding - CW'(1);
                default: r_outstanding <= r_outstanding;
            endcase
        end
    end

    assign gains = '{
        prop_gain:   r_prop_gain,
        integ_gain:  r_integ_gain,
        deriv_gain:  r_deriv_gain,
        integ_limit: r_integ_limit,
        drive_limit: r_drive_limit
    };

    wap_wrap #(
        .MOTORS (MOTORS)
    ) u_wrap (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_acc),
        .i_motor_sel      (i_motor_sel),
        .i_target_angle   (i_target_angle),
        .i_measured_angle (i_measured_angle),
        .o_item           (item)
    );

    wap_state_mem #(
        .MOTORS (MOTORS)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    wap_update #(
        .MOTORS (MOTORS)
    ) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gains   (gains),
        .i_item    (item),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_result  (result)
    );

    wap_out_fifo u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (result),
        .i_pop   (out_acc),
        .o_valid (o_out_valid),
        .o_word  (out_word)
    );

    assign o_motor_out   = out_word.motor;
    assign o_drive_value = out_word.drive;

endmodule

`default_nettype wire
